// ----- rtl/core/awbd_pkg.sv -----
// Shared types and constants of the alpha-weighted 2x2 box downsampler.
// Used by the channel interfaces, the averaging unit and the top level.
`default_nettype none

package awbd_pkg;

  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_W        = 12;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int CHAN_CFG_W   = 3;
  localparam int WSUM_W       = 18;
  localparam int SUM_W        = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [CHAN_CFG_W-1:0] CHAN_ONE  = 3'd1;
  localparam logic [CHAN_CFG_W-1:0] CHAN_TWO  = 3'd2;
  localparam logic [CHAN_CFG_W-1:0] CHAN_THREE = 3'd3;
  localparam logic [CHAN_CFG_W-1:0] CHAN_ALPHA = 3'd4;

  // Channel 0 sits in the low byte, so a cast to 32 bits packs the pixel.
  typedef struct packed {
    logic [7:0] chan3;
    logic [7:0] chan2;
    logic [7:0] chan1;
    logic [7:0] chan0;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
    logic [7:0] out3;
    logic       row_end;
    logic       frame_end;
  } out_word_t;

  // One 2x2 block handed from the pixel front end to the averaging unit.
  typedef struct packed {
    logic [31:0]           left;
    logic [31:0]           right;
    logic                  from_store;
    logic [CHAN_CFG_W-1:0] chans;
    logic                  row_end;
    logic                  frame_end;
  } job_t;

  typedef enum logic [2:0] {
    AV_IDLE,
    AV_FETCH,
    AV_MAC,
    AV_PREP,
    AV_DIV,
    AV_DONE
  } avg_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/awbd_if.sv -----
// Valid/ready channel interfaces of the downsampler: source pixels,
// downsampled pixels and register writes. Depends on awbd_pkg.
`default_nettype none

interface awbd_in_if;
  logic               valid;
  logic               ready;
  awbd_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface awbd_out_if;
  logic                valid;
  logic                ready;
  awbd_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface awbd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [awbd_pkg::CFG_INDEX_W-1:0]     index;
  logic [awbd_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/awbd_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module awbd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/awbd_avg.sv -----
// Averaging unit: accumulates the four pixels of a 2x2 block, divides the
// alpha-weighted sums bit by bit when four channels are set, and holds the
// result in an output register. Depends on awbd_pkg and awbd_out_if.
`default_nettype none

module awbd_avg (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  awbd_pkg::job_t  job,
  input  logic [63:0]     store_data,
  output logic            idle,
  awbd_out_if.source      block
);
  import awbd_pkg::*;

  avg_state_t state, state_next;

  logic [31:0]           pix [4];
  logic [CHAN_CFG_W-1:0] chans;
  logic                  row_end;
  logic                  frame_end;
  logic [1:0]            step;
  logic [WSUM_W-1:0]     wsum [3];
  logic [SUM_W-1:0]      psum [3];
  logic [SUM_W-1:0]      asum;
  logic [WSUM_W-1:0]     rem [3];
  logic [7:0]            quo [3];
  logic [2:0]            bit_idx;
  logic                  out_valid;
  out_word_t             out_data;

  logic [31:0]       cur;
  logic [7:0]        alpha;
  logic [15:0]       prod [3];
  logic [WSUM_W-1:0] dshift;
  logic [7:0]        plain [3];
  logic [SUM_W:0]    round_sum [3];
  logic [SUM_W:0]    alpha_round;
  logic              load_out;
  out_word_t         result;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      AV_IDLE:  if (start) state_next = job.from_store ? AV_FETCH : AV_MAC;
      AV_FETCH: state_next = AV_MAC;
      AV_MAC:   if (step == 2'd3) state_next = (chans == CHAN_ALPHA) ? AV_PREP : AV_DONE;
      AV_PREP:  state_next = AV_DIV;
      AV_DIV:   if (bit_idx == 3'd0) state_next = AV_DONE;
      AV_DONE:  if (load_out) state_next = AV_IDLE;
      default:  state_next = AV_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    idle     = (state == AV_IDLE);
    load_out = (state == AV_DONE) && (!out_valid || block.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath of the multiply-accumulate and divide steps.
  always_comb begin
    cur    = pix[step];
    alpha  = cur[31:24];
    dshift = WSUM_W'(asum) << bit_idx;
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch]      = cur[8*ch +: 8] * alpha;
      round_sum[ch] = {1'b0, psum[ch]} + (SUM_W+1)'(2);
      plain[ch]     = round_sum[ch][SUM_W-1:2];
    end
    alpha_round = {1'b0, asum} + (SUM_W+1)'(2);
  end

  always_ff @(posedge clk) begin
    unique case (state)
      AV_IDLE: begin
        if (start) begin
          pix[0]    <= job.left;
          pix[1]    <= job.right;
          pix[2]    <= job.left;
          pix[3]    <= job.right;
          chans     <= job.chans;
          row_end   <= job.row_end;
          frame_end <= job.frame_end;
          step      <= 2'd0;
          asum      <= '0;
          for (int ch = 0; ch < 3; ch++) begin
            wsum[ch] <= '0;
            psum[ch] <= '0;
          end
        end
      end
      AV_FETCH: begin
        pix[0] <= store_data[31:0];
        pix[1] <= store_data[63:32];
      end
      AV_MAC: begin
        step <= step + 2'd1;
        asum <= asum + SUM_W'(alpha);
        for (int ch = 0; ch < 3; ch++) begin
          wsum[ch] <= wsum[ch] + WSUM_W'(prod[ch]);
          psum[ch] <= psum[ch] + SUM_W'(cur[8*ch +: 8]);
        end
      end
      AV_PREP: begin
        bit_idx <= 3'd7;
        for (int ch = 0; ch < 3; ch++) begin
          rem[ch] <= wsum[ch] + WSUM_W'(asum >> 1);
        end
      end
      AV_DIV: begin
        // Restoring division, one quotient bit per cycle; the rounded
        // weighted average never exceeds 255, so eight bits suffice.
        bit_idx <= bit_idx - 3'd1;
        for (int ch = 0; ch < 3; ch++) begin
          if (rem[ch] >= dshift) begin
            rem[ch]          <= rem[ch] - dshift;
            quo[ch][bit_idx] <= 1'b1;
          end else begin
            quo[ch][bit_idx] <= 1'b0;
          end
        end
      end
      AV_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result           = '0;
    result.row_end   = row_end;
    result.frame_end = frame_end;
    if (chans == CHAN_ALPHA) begin
      result.out0 = (asum != '0) ? quo[0] : plain[0];
      result.out1 = (asum != '0) ? quo[1] : plain[1];
      result.out2 = (asum != '0) ? quo[2] : plain[2];
      result.out3 = alpha_round[SUM_W-1:2];
    end else begin
      result.out0 = plain[0];
      result.out1 = (chans >= CHAN_TWO) ? plain[1] : 8'd0;
      result.out2 = (chans >= CHAN_THREE) ? plain[2] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (block.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= result;
    end
  end

  assign block.valid = out_valid;
  assign block.data  = out_data;

endmodule

`default_nettype wire

// ----- rtl/core/alpha_weighted_box_downsample_2x.sv -----
// Alpha-weighted 2x2 box downsampler. A pixel that closes a block starts the averaging
// unit, and the input is held until that unit is idle again: through the line store read
// on an odd row, the 4-step accumulate and, with four channels, the 8-step quotient loop.
// The word is loaded into the output register at the end; an earlier word still waiting
// at the output stretches the hold.
// Reset sets width 1, height 1, four channels and restarts the frame; the line store is kept.
`default_nettype none

module alpha_weighted_box_downsample_2x #(
  parameter int MAX_SOURCE_WIDTH = 4096
) (
  input  logic       clk,
  input  logic       rst,
  awbd_in_if.sink    pixel,
  awbd_out_if.source block,
  awbd_cfg_if.sink   cfg
);
  import awbd_pkg::*;

  localparam int DEPTH = (MAX_SOURCE_WIDTH + 1) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_SOURCE_WIDTH);
  localparam int LW    = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] source_width;
  logic [CFG_DATA_W-1:0] source_height;
  logic [CHAN_CFG_W-1:0] channel_count;
  logic [31:0]           held_pixel;
  logic [CW-1:0]         column_count;
  logic [ROW_W-1:0]      row_count;

  logic [LW-1:0]         col_limit;
  logic [ROW_W-1:0]      row_limit;
  logic [CHAN_CFG_W-1:0] eff_chans;
  logic                  last_col;
  logic                  last_row;
  logic                  pair_done;
  logic                  in_fire;
  logic                  store_we;
  logic                  emit;
  logic [31:0]           cur;
  logic [31:0]           left;
  logic [63:0]           store_rdata;
  logic                  avg_idle;
  job_t                  job;

  always_comb begin
    if (source_width == '0) begin
      col_limit = '0;
    end else if (int'(source_width) > MAX_SOURCE_WIDTH) begin
      col_limit = LW'(MAX_SOURCE_WIDTH - 1);
    end else begin
      col_limit = LW'(source_width) - LW'(1);
    end

    if (source_height == '0) begin
      row_limit = '0;
    end else if (int'(source_height) > HEIGHT_LIMIT) begin
      row_limit = ROW_W'(HEIGHT_LIMIT - 1);
    end else begin
      row_limit = ROW_W'(source_height - CFG_DATA_W'(1));
    end

    if (channel_count == '0) begin
      eff_chans = CHAN_ONE;
    end else if (channel_count > CHAN_ALPHA) begin
      eff_chans = CHAN_ALPHA;
    end else begin
      eff_chans = channel_count;
    end
  end

  assign cur       = 32'(pixel.data);
  assign last_col  = (LW'(column_count) == col_limit);
  assign last_row  = (row_count == row_limit);
  assign pair_done = column_count[0] || last_col;
  assign left      = column_count[0] ? held_pixel : cur;
  assign in_fire   = pixel.valid && pixel.ready;
  // Even rows other than the last only park their pairs for the row below.
  assign store_we  = in_fire && pair_done && !row_count[0] && !last_row;
  assign emit      = in_fire && pair_done && (row_count[0] || last_row);

  // A register write takes the cycle, so no pixel is taken alongside it.
  assign pixel.ready = avg_idle && !cfg.valid;
  assign cfg.ready   = 1'b1;

  always_comb begin
    job.left       = left;
    job.right      = cur;
    job.from_store = row_count[0];
    job.chans      = eff_chans;
    job.row_end    = last_col;
    job.frame_end  = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= CFG_DATA_W'(1);
      source_height <= CFG_DATA_W'(1);
      channel_count <= CHAN_ALPHA;
      held_pixel    <= '0;
      column_count  <= '0;
      row_count     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SOURCE_WIDTH: begin
          source_width <= cfg.data;
          held_pixel   <= '0;
          column_count <= '0;
          row_count    <= '0;
        end
        REG_SOURCE_HEIGHT: begin
          source_height <= cfg.data;
          held_pixel    <= '0;
          column_count  <= '0;
          row_count     <= '0;
        end
        REG_CHANNEL_COUNT: begin
          channel_count <= cfg.data[CHAN_CFG_W-1:0];
          held_pixel    <= '0;
          column_count  <= '0;
          row_count     <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      if (!column_count[0]) begin
        held_pixel <= cur;
      end
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  awbd_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_even_row_store (
    .clk   (clk),
    .we    (store_we),
    .addr  (AW'(column_count >> 1)),
    .wdata ({cur, left}),
    .rdata (store_rdata)
  );

  awbd_avg u_avg (
    .clk        (clk),
    .rst        (rst),
    .start      (emit),
    .job        (job),
    .store_data (store_rdata),
    .idle       (avg_idle),
    .block      (block)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the alpha-weighted 2x2 box downsampler: a short
// table of directed pixels, then random frames checked against a local predictor.
// Depends on awbd_pkg, the awbd channel interfaces and the downsampler top level.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import awbd_pkg::*;

  localparam int SRC_WIDTH_MAX = 4096;
  localparam int STORE_DEPTH   = (SRC_WIDTH_MAX + 1) / 2;
  localparam int ITEM_TARGET   = 1350;
  localparam int END_STEADY    = 200;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int PRESSURE_PX   = 48;
  localparam int DIRECTED_LEN  = 33;

  // Index past the last register; a write to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;
  typedef enum int {ALPHA_CLEAR, ALPHA_OPAQUE, ALPHA_MIXED} alpha_mode_t;

  typedef struct packed {
    step_kind_t             kind;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
    in_word_t               px;
    logic                   typed;
    out_word_t              want;
  } step_t;

  logic clk;
  logic rst;

  awbd_in_if  pixel_bus ();
  awbd_out_if block_bus ();
  awbd_cfg_if cfg_bus ();

  alpha_weighted_box_downsample_2x #(
    .MAX_SOURCE_WIDTH(SRC_WIDTH_MAX)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .pixel(pixel_bus),
    .block(block_bus),
    .cfg  (cfg_bus)
  );

  // Predictor state.
  logic [63:0]           line_store [STORE_DEPTH];
  logic [31:0]           held_px;
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  logic [CHAN_CFG_W-1:0] chans_reg;

  out_word_t expected_blocks [$];
  step_t     directed_steps [DIRECTED_LEN];

  int mismatches;
  int pixels_sent;
  int blocks_seen;
  int settings_used;
  bit steady;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > SRC_WIDTH_MAX) return SRC_WIDTH_MAX;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return height_reg;
  endfunction

  function automatic int unsigned eff_chans();
    if (chans_reg == 0) return CHAN_ONE;
    if (chans_reg > CHAN_ALPHA) return CHAN_ALPHA;
    return chans_reg;
  endfunction

  function automatic out_word_t box_average(logic [31:0] a, logic [31:0] b,
                                            logic [31:0] c, logic [31:0] d,
                                            int unsigned n);
    logic [31:0] blk [4];
    logic [7:0]  v [4];
    int unsigned asum;
    int unsigned wsum;
    int unsigned sum;
    out_word_t   res;
    blk[0] = a;
    blk[1] = b;
    blk[2] = c;
    blk[3] = d;
    for (int ch = 0; ch < 4; ch++) v[ch] = 8'h00;
    if (n == CHAN_ALPHA) begin
      asum = 0;
      for (int k = 0; k < 4; k++) asum += blk[k][31:24];
      for (int ch = 0; ch < 3; ch++) begin
        sum  = 0;
        wsum = 0;
        for (int k = 0; k < 4; k++) begin
          sum  += blk[k][8*ch +: 8];
          wsum += blk[k][8*ch +: 8] * blk[k][31:24];
        end
        // Fully transparent blocks fall back to the plain rounded mean.
        if (asum > 0) v[ch] = 8'((wsum + asum / 2) / asum);
        else v[ch] = 8'((sum + 2) / 4);
      end
      v[3] = 8'((asum + 2) / 4);
    end else begin
      for (int ch = 0; ch < n; ch++) begin
        sum = 0;
        for (int k = 0; k < 4; k++) sum += blk[k][8*ch +: 8];
        v[ch] = 8'((sum + 2) / 4);
      end
    end
    res      = '0;
    res.out0 = v[0];
    res.out1 = v[1];
    res.out2 = v[2];
    res.out3 = v[3];
    return res;
  endfunction

  // Advances the predictor by one source pixel; returns 1 when a block closes.
  function automatic bit downsample_step(in_word_t px, output out_word_t res);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned idx;
    logic [31:0] up_l;
    logic [31:0] up_r;
    bit          last_col;
    bit          last_row;
    bit          made;
    w = eff_width();
    h = eff_height();
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    last_col = (c == w - 1);
    last_row = (r == h - 1);
    idx = c / 2;
    if (idx >= STORE_DEPTH) idx = STORE_DEPTH - 1;
    made = 1'b0;
    res  = '0;
    if (c % 2 == 0) held_px = px;
    if ((c % 2 == 1) || last_col) begin
      if ((r % 2 == 0) && !last_row) begin
        line_store[idx] = {32'(px), held_px};
      end else begin
        if (r % 2 == 1) begin
          {up_r, up_l} = line_store[idx];
        end else begin
          up_l = held_px;
          up_r = px;
        end
        res = box_average(up_l, up_r, held_px, px, eff_chans());
        res.row_end   = last_col;
        res.frame_end = last_col && last_row;
        made = 1'b1;
      end
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    return made;
  endfunction

  function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_SOURCE_WIDTH: width_reg = value;
      REG_SOURCE_HEIGHT: height_reg = value;
      REG_CHANNEL_COUNT: chans_reg = value[CHAN_CFG_W-1:0];
      default: return;
    endcase
    held_px = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_word_t make_pixel(alpha_mode_t mode);
    in_word_t p;
    p.chan0 = rand_byte();
    p.chan1 = rand_byte();
    p.chan2 = rand_byte();
    case (mode)
      ALPHA_CLEAR: p.chan3 = 8'h00;
      ALPHA_OPAQUE: p.chan3 = 8'hFF;
      default: p.chan3 = ($urandom_range(0, 4) == 0) ? 8'h00 : rand_byte();
    endcase
    return p;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_pixel(in_word_t px, bit typed, out_word_t want);
    out_word_t got;
    bit        made;
    if (!steady && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      pixel_bus.valid = 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk);
    end
    @(negedge clk);
    pixel_bus.valid = 1'b1;
    pixel_bus.data  = px;
    do @(posedge clk); while (!pixel_bus.ready);
    made = downsample_step(px, got);
    pixels_sent++;
    if (made) expected_blocks.push_back(typed ? want : got);
  endtask

  // Waits until every expected word is out and the block has finished any
  // store update that closes no block.
  task automatic wait_idle();
    @(negedge clk);
    pixel_bus.valid = 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = value;
    do @(posedge clk); while (!cfg_bus.ready);
    apply_register(idx, value);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && block_bus.valid && block_bus.ready) begin
      blocks_seen++;
      if (expected_blocks.size() == 0) begin
        $error("downsampled word %h arrived with none expected", block_bus.data);
        mismatches++;
      end else begin
        want = expected_blocks.pop_front();
        check_field("out0", want.out0, block_bus.data.out0);
        check_field("out1", want.out1, block_bus.data.out1);
        check_field("out2", want.out2, block_bus.data.out2);
        check_field("out3", want.out3, block_bus.data.out3);
        check_field("row_end", want.row_end, block_bus.data.row_end);
        check_field("frame_end", want.frame_end, block_bus.data.frame_end);
      end
    end
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    block_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        block_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        block_bus.ready = 1'b0;
        stall_left--;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
        block_bus.ready = 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        block_bus.ready = 1'b1;
      end
    end
  end

  initial begin
    int unsigned           shape;
    int unsigned           frames;
    int unsigned           tail;
    int unsigned           frame_px;
    alpha_mode_t           alpha_mode;
    logic [CFG_DATA_W-1:0] width_val;
    logic [CFG_DATA_W-1:0] height_val;
    logic [CFG_DATA_W-1:0] chans_val;

    rst             = 1'b1;
    pixel_bus.valid = 1'b0;
    pixel_bus.data  = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = '0;
    cfg_bus.data    = '0;
    steady          = 1'b0;
    hold_req        = 1'b0;
    mismatches      = 0;
    pixels_sent     = 0;
    blocks_seen     = 0;
    settings_used   = 0;
    held_px         = '0;
    col_pos         = 0;
    row_pos         = 0;
    width_reg       = 13'd1;
    height_reg      = 13'd1;
    chans_reg       = CHAN_ALPHA;

    // A 1x1 frame repeats one pixel four times, so the enabled channels equal the input and the others are zero.
    directed_steps = '{
      '{STEP_PIXEL, '0, '0, 32'hFFFFFFFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}},
      '{STEP_PIXEL, '0, '0, 32'h00000000, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
      '{STEP_PIXEL, '0, '0, 32'h00563412, 1'b1, '{8'h12, 8'h34, 8'h56, 8'h00, 1'b1, 1'b1}},
      '{STEP_PIXEL, '0, '0, 32'h800155AA, 1'b1, '{8'hAA, 8'h55, 8'h01, 8'h80, 1'b1, 1'b1}},
      '{STEP_WRITE, REG_CHANNEL_COUNT, 13'd0, '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h11223344, 1'b1, '{8'h44, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
      '{STEP_WRITE, REG_CHANNEL_COUNT, 13'(CHAN_TWO), '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'hA0B0C0D0, 1'b1, '{8'hD0, 8'hC0, 8'h00, 8'h00, 1'b1, 1'b1}},
      '{STEP_WRITE, REG_CHANNEL_COUNT, 13'(CHAN_THREE), '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h0F1E2D3C, 1'b1, '{8'h3C, 8'h2D, 8'h1E, 8'h00, 1'b1, 1'b1}},
      '{STEP_WRITE, REG_CHANNEL_COUNT, 13'h1FFF, '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h01FF807F, 1'b1, '{8'h7F, 8'h80, 8'hFF, 8'h01, 1'b1, 1'b1}},
      '{STEP_WRITE, REG_UNUSED, 13'h1FFF, '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'hFE000000, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hFE, 1'b1, 1'b1}},
      '{STEP_WRITE, REG_SOURCE_WIDTH, 13'd0, '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h00FFFFFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1}},
      '{STEP_WRITE, REG_SOURCE_WIDTH, 13'd2, '0, 1'b0, '0},
      '{STEP_WRITE, REG_SOURCE_HEIGHT, 13'd2, '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h00010203, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h00FF00FE, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h00000000, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h00808080, 1'b0, '0},
      '{STEP_WRITE, REG_SOURCE_WIDTH, 13'd3, '0, 1'b0, '0},
      '{STEP_WRITE, REG_SOURCE_HEIGHT, 13'd3, '0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'hFF102030, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h00C0B0A0, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h80FF0000, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h40112233, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h00000000, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h01FFFFFF, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'hFF0000FF, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h7F7F7F7F, 1'b0, '0},
      '{STEP_PIXEL, '0, '0, 32'h00ABCDEF, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_WRITE) begin
        write_register(directed_steps[i].reg_index, directed_steps[i].reg_value);
      end else begin
        send_pixel(directed_steps[i].px, directed_steps[i].typed, directed_steps[i].want);
      end
    end

    // Hold the output off while pixels keep coming, so the input backs up.
    write_register(REG_SOURCE_WIDTH, 13'd4);
    write_register(REG_SOURCE_HEIGHT, 13'd2);
    write_register(REG_CHANNEL_COUNT, 13'(CHAN_ALPHA));
    steady   = 1'b1;
    hold_req = 1'b1;
    for (int k = 0; k < PRESSURE_PX; k++) send_pixel(make_pixel(ALPHA_MIXED), 1'b0, '0);
    steady = 1'b0;

    while (pixels_sent < ITEM_TARGET) begin
      // The first settings force the saturated sizes and the zero sizes.
      case (settings_used)
        0: shape = 0;
        1: shape = 1;
        2: shape = 3;
        default: shape = $urandom_range(0, 19);
      endcase
      chans_val = 13'($urandom_range(0, 8191));
      if ($urandom_range(0, 1) == 0) chans_val[CHAN_CFG_W-1:0] = CHAN_ALPHA;
      frames = 1;
      tail   = 0;
      case (shape)
        0: begin
          width_val  = ($urandom_range(0, 1) == 0) ? 13'd4096 : 13'($urandom_range(4097, 8191));
          height_val = 13'd1;
          frames     = 0;
        end
        1: begin
          width_val  = 13'($urandom_range(1, 5));
          height_val = ($urandom_range(0, 1) == 0) ? 13'd4096 : 13'($urandom_range(4097, 8191));
          frames     = 0;
        end
        2: begin
          width_val  = 13'($urandom_range(13, 70));
          height_val = 13'($urandom_range(1, 4));
        end
        3: begin
          width_val  = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
          height_val = (width_val == 0) ? 13'($urandom_range(0, 5)) : 13'd0;
          frames     = 2;
        end
        default: begin
          width_val  = 13'($urandom_range(1, 12));
          height_val = 13'($urandom_range(1, 8));
          frames     = $urandom_range(1, 3);
        end
      endcase
      write_register(REG_SOURCE_WIDTH, width_val);
      write_register(REG_SOURCE_HEIGHT, height_val);
      write_register(REG_CHANNEL_COUNT, chans_val);
      if ($urandom_range(0, 4) == 0) write_register(REG_UNUSED, 13'($urandom_range(0, 8191)));
      settings_used++;

      frame_px = eff_width() * eff_height();
      case (shape)
        0: tail = 40;
        1: tail = 3 * eff_width();
        default: begin
          // Some frames are cut short; the next register write restarts them.
          if ($urandom_range(0, 3) == 0 && frame_px > 1) tail = $urandom_range(1, frame_px - 1);
        end
      endcase

      alpha_mode = ALPHA_MIXED;
      for (int unsigned k = 0; k < frames * frame_px + tail; k++) begin
        if (k % frame_px == 0) begin
          case ($urandom_range(0, 3))
            0: alpha_mode = ALPHA_CLEAR;
            1: alpha_mode = ALPHA_OPAQUE;
            default: alpha_mode = ALPHA_MIXED;
          endcase
        end
        steady = (pixels_sent >= ITEM_TARGET - END_STEADY);
        send_pixel(make_pixel(alpha_mode), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Run covered %0d source pixels and %0d downsampled words over %0d random settings,",
             pixels_sent, blocks_seen, settings_used);
    $display("with edge clamping, transparent blocks, saturated sizes and output back-pressure.");
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/awbd_pkg.sv
rtl/core/awbd_if.sv
rtl/core/awbd_ram.sv
rtl/core/awbd_avg.sv
rtl/core/alpha_weighted_box_downsample_2x.sv
tb/sv/tb.sv
